[hw/rtl/nar_pkg.sv]
// ----------------------------------------------------------------------------
// nar_pkg
// Types, codes and constants shared by the name/address registry modules.
// ----------------------------------------------------------------------------
package nar_pkg;

  localparam int unsigned SLOTS_DEFAULT = 64;
  localparam logic [31:0] FRESH_NAME_SEED = 32'h00fa_cade;

  typedef enum logic [2:0] {
    MODE_REG          = 3'd0,
    MODE_DROP_NAME    = 3'd1,
    MODE_DROP_ADDR    = 3'd2,
    MODE_NAME_OF_ADDR = 3'd3,
    MODE_ADDR_OF_NAME = 3'd4,
    MODE_TYPE_OF_NAME = 3'd5,
    MODE_NAME_OF_TASK = 3'd6,
    MODE_READ_SLOT    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key_name;
    logic [31:0] key_addr;
    logic [7:0]  res_type;
    logic [31:0] task_handle;
    logic [21:0] task_pid;
    logic [6:0]  slot_index;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [6:0]  slot_out;
    logic [31:0] name_out;
    logic [31:0] addr_out;
    logic [7:0]  type_out;
    logic [31:0] task_out;
    logic [21:0] pid_out;
  } out_beat_t;

  // One registry entry as stored in the memory.
  typedef struct packed {
    logic [31:0] name;
    logic [31:0] addr;
    logic [7:0]  rtype;
    logic [31:0] handle;
    logic [21:0] pid;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the match unit.
  typedef struct packed {
    logic  clear;
    logic  rd_vld;
    mode_t mode;
  } scan_ctl_t;

  // Match records collected over one scan.
  typedef struct packed {
    logic   hit;
    logic   free_hit;
    entry_t entry;
  } match_rec_t;

endpackage

[hw/rtl/nar_ram.sv]
// ----------------------------------------------------------------------------
// nar_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module nar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/nar_match.sv]
// ----------------------------------------------------------------------------
// nar_match
// Compares each entry read during a scan against the operation key and keeps
// the first primary hit and the first free slot.
// ----------------------------------------------------------------------------
module nar_match
  import nar_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned SW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_ctl_t     ctl,
  input  in_beat_t      op,
  input  logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output match_rec_t    rec,
  output logic [SW-1:0] hit_slot,
  output logic [SW-1:0] free_slot
);

  logic          hit_r, hit_nxt;
  logic          free_hit_r, free_hit_nxt;
  entry_t        entry_r, entry_nxt;
  logic [SW-1:0] hit_slot_r, hit_slot_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;
  logic          prim;
  logic [SW-1:0] rd_slot;

  assign rd_slot = SW'(rd_addr) + SW'(1);

  always_comb begin
    case (ctl.mode)
      MODE_REG, MODE_DROP_NAME, MODE_ADDR_OF_NAME, MODE_TYPE_OF_NAME:
        prim = (rd_data.name == op.key_name);
      MODE_DROP_ADDR, MODE_NAME_OF_ADDR:
        prim = (rd_data.addr == op.key_addr);
      MODE_NAME_OF_TASK:
        prim = (rd_data.handle == op.task_handle) && (rd_data.pid == op.task_pid);
      MODE_READ_SLOT:
        prim = (rd_data.name != '0);
      default:
        prim = 1'b0;
    endcase
  end

  always_comb begin
    hit_nxt       = hit_r;
    free_hit_nxt  = free_hit_r;
    entry_nxt     = entry_r;
    hit_slot_nxt  = hit_slot_r;
    free_slot_nxt = free_slot_r;
    if (ctl.clear) begin
      hit_nxt      = 1'b0;
      free_hit_nxt = 1'b0;
    end else if (ctl.rd_vld) begin
      // keep only the lowest matching slot
      if (prim && !hit_r) begin
        hit_nxt      = 1'b1;
        entry_nxt    = rd_data;
        hit_slot_nxt = rd_slot;
      end
      if ((rd_data.name == '0) && !free_hit_r) begin
        free_hit_nxt  = 1'b1;
        free_slot_nxt = rd_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      free_hit_r <= 1'b0;
    end else begin
      hit_r      <= hit_nxt;
      free_hit_r <= free_hit_nxt;
    end
    entry_r     <= entry_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
  end

  assign rec.hit      = hit_r;
  assign rec.free_hit = free_hit_r;
  assign rec.entry    = entry_r;
  assign hit_slot     = hit_slot_r;
  assign free_slot    = free_slot_r;

endmodule

[hw/rtl/name_address_registry_unit.sv]
// ----------------------------------------------------------------------------
// name_address_registry_unit
// Associative registry of SLOTS entries held in one memory, searched by scan.
// ----------------------------------------------------------------------------
// The block takes one operation at a time. After reset it clears every slot of
// the entry memory and stalls the input channel meanwhile. Every searching
// operation (register, drop, name of a nonzero address, address of name, type,
// name of task) scans all slots through the single memory port, one entry a
// cycle; a drain step then takes in the last read, and the finish step writes
// back and loads the result, waiting while the previous result is still held.
// Read slot reads and drains the indexed entry, or goes straight to finish
// when the index lies outside 1..SLOTS, as does a fresh name request. The result
// sits in an output register, so a new beat is taken while the previous waits.
module name_address_registry_unit
  import nar_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

  state_t        state_r, state_nxt;
  in_beat_t      op_r, op_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic [31:0]   fresh_r, fresh_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_r, out_nxt;

  logic          accept;
  logic          out_free;
  logic          load;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata, mem_rdata;
  logic [ENTRY_W-1:0] mem_rbits;
  logic          in_range;
  logic [31:0]   idx_ext, idx_m1;
  scan_ctl_t     sctl;
  match_rec_t    rec;
  logic [SW-1:0] hit_slot, free_slot;
  logic [SW-1:0] wr_slot;
  logic          wr_en;
  entry_t        wr_entry;
  out_beat_t     res;
  logic          fresh_bump;
  logic [31:0]   slot_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == ST_FINISH) && out_free;

  // range check for read slot, on the captured operation
  assign idx_ext  = {25'd0, op_r.slot_index};
  assign idx_m1   = idx_ext - 32'd1;
  assign in_range = (op_r.slot_index != '0) && (idx_ext <= 32'(SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if ((mode_t'(in_data.mode) == MODE_NAME_OF_ADDR) && (in_data.key_addr == '0)) begin
            state_nxt = ST_FINISH;
          end else if (mode_t'(in_data.mode) == MODE_READ_SLOT) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_DRAIN;
      end
      ST_READ: begin
        state_nxt = in_range ? ST_DRAIN : ST_FINISH;
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // result and write-back of the finishing operation
  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    wr_slot  = free_slot;
    wr_entry = '0;
    fresh_bump = 1'b0;
    case (mode_t'(op_r.mode))
      MODE_REG: begin
        // refuse when the first slot with this name holds an address, or no slot is free
        if (!(rec.hit && (rec.entry.addr != '0)) && rec.free_hit) begin
          wr_en           = 1'b1;
          wr_slot         = free_slot;
          wr_entry.name   = op_r.key_name;
          wr_entry.addr   = op_r.key_addr;
          wr_entry.rtype  = op_r.res_type;
          wr_entry.handle = op_r.task_handle;
          wr_entry.pid    = op_r.task_pid;
          res.found       = 1'b1;
        end
      end
      MODE_DROP_NAME, MODE_DROP_ADDR: begin
        if (rec.hit) begin
          wr_en     = 1'b1;
          wr_slot   = hit_slot;
          res.found = 1'b1;
        end
      end
      MODE_NAME_OF_ADDR: begin
        if (op_r.key_addr == '0) begin
          res.found    = 1'b1;
          res.name_out = fresh_r;
          fresh_bump   = 1'b1;
        end else if (rec.hit) begin
          res.found    = 1'b1;
          res.name_out = rec.entry.name;
        end
      end
      MODE_ADDR_OF_NAME: begin
        res.found    = rec.hit;
        res.addr_out = rec.hit ? rec.entry.addr : '0;
      end
      MODE_TYPE_OF_NAME: begin
        res.found    = rec.hit;
        res.type_out = rec.hit ? rec.entry.rtype : '0;
      end
      MODE_NAME_OF_TASK: begin
        res.found    = rec.hit;
        res.name_out = rec.hit ? rec.entry.name : '0;
      end
      MODE_READ_SLOT: begin
        if (in_range && rec.hit) begin
          res.found    = 1'b1;
          res.name_out = rec.entry.name;
          res.addr_out = rec.entry.addr;
          res.type_out = rec.entry.rtype;
          res.task_out = rec.entry.handle;
          res.pid_out  = rec.entry.pid;
        end
      end
      default: res = '0;
    endcase
    if (!res.found || fresh_bump) begin
      slot_ext = '0;
    end else if (wr_en) begin
      slot_ext = 32'(wr_slot);
    end else begin
      slot_ext = 32'(hit_slot);
    end
    res.slot_out = slot_ext[6:0];
  end

  // memory and register controls
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cnt_r;
    mem_wdata = '0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    sctl.clear  = 1'b0;
    sctl.rd_vld = rd_vld_r;
    sctl.mode   = mode_t'(op_r.mode);
    fresh_nxt     = fresh_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = (cnt_r == LAST_ADDR) ? '0 : cnt_r + AW'(1);
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          op_nxt = in_data;
          // pid counts only with a task handle
          if (in_data.task_handle == '0) op_nxt.task_pid = '0;
          sctl.clear = 1'b1;
        end
      end
      ST_SCAN: begin
        mem_re  = 1'b1;
        cnt_nxt = (cnt_r == LAST_ADDR) ? '0 : cnt_r + AW'(1);
      end
      ST_READ: begin
        mem_re   = in_range;
        mem_addr = idx_m1[AW-1:0];
      end
      ST_FINISH: begin
        if (load) begin
          mem_we        = wr_en;
          mem_addr      = AW'(wr_slot - SW'(1));
          mem_wdata     = wr_entry;
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          if (fresh_bump) fresh_nxt = fresh_r + 32'd1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      fresh_r     <= FRESH_NAME_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= mem_re;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    rd_addr_r <= mem_addr;
    out_r     <= out_nxt;
  end

  nar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rbits)
  );

  assign mem_rdata = entry_t'(mem_rbits);

  nar_match #(
    .SLOTS (SLOTS)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .op        (op_r),
    .rd_addr   (rd_addr_r),
    .rd_data   (mem_rdata),
    .rec       (rec),
    .hit_slot  (hit_slot),
    .free_slot (free_slot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a new result appears only from the finishing step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result loaded outside finish");

  // memory writes only during the clearing pass or the write-back
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_FINISH))
    else $error("memory write outside clear or finish");

  // reads and writes never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("read and write in the same cycle");

  // a failed result carries no slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.slot_out == '0))
    else $error("slot reported on failure");

endmodule
